### src/dca_pkg.sv
// Package for the debounced current alarm: alert classes, state and config types.
package dca_pkg;

    typedef enum logic [1:0] {
        CLASS_NONE = 2'd0,
        CLASS_HIGH = 2'd1,
        CLASS_LOW  = 2'd2
    } t_class;

    // Configuration register indexes
    localparam logic [2:0] REG_DEBOUNCE = 3'd0;
    localparam logic [2:0] REG_COOLDOWN = 3'd1;
    localparam logic [2:0] REG_HIGH_THR = 3'd2;
    localparam logic [2:0] REG_LOW_THR  = 3'd3;
    localparam logic [2:0] REG_FLOOR    = 3'd4;

    // Reset values of the configuration registers
    localparam logic [7:0]         RST_DEBOUNCE = 8'd3;
    localparam logic [31:0]        RST_COOLDOWN = 32'd60000;
    localparam logic signed [15:0] RST_HIGH_THR = 16'sd10000;
    localparam logic signed [15:0] RST_LOW_THR  = 16'sd1000;
    localparam logic signed [15:0] RST_FLOOR    = 16'sd150;

    localparam logic [7:0] RUN_MAX = 8'd255;

    typedef struct packed {
        logic [7:0]         debounce_count;
        logic [31:0]        cooldown_ms;
        logic signed [15:0] high_threshold_ma;
        logic signed [15:0] low_threshold_ma;
        logic signed [15:0] floor_ma;
    } t_cfg;

    typedef struct packed {
        t_class      active_alert;
        t_class      candidate_class;
        logic [7:0]  breach_run;
        logic [47:0] last_raise_ms;   // zero means never raised
    } t_state;

endpackage

### src/dca_step.sv
// Per-beat alarm update: classify the sample, advance the run, apply cooldown; a clear resets.
module dca_step
    import dca_pkg::*;
(
    input  t_cfg               i_cfg,
    input  t_state             i_state,
    input  logic               i_kind,
    input  logic signed [15:0] i_current_ma,
    input  logic [47:0]        i_now_ms,
    output t_state             o_state
);

    t_class      det;
    logic [7:0]  run_new;
    logic [47:0] elapsed;
    logic        cool_ok;

    always_comb begin
        if (i_current_ma > i_cfg.high_threshold_ma) begin
            det = CLASS_HIGH;
        end else if ((i_current_ma > i_cfg.floor_ma) &&
                     (i_current_ma < i_cfg.low_threshold_ma)) begin
            det = CLASS_LOW;
        end else begin
            det = CLASS_NONE;
        end
    end

    always_comb begin
        if (det == i_state.candidate_class) begin
            run_new = (i_state.breach_run == RUN_MAX) ? RUN_MAX
                                                      : i_state.breach_run + 8'd1;
        end else begin
            run_new = 8'd1;
        end
    end

    // Wraps modulo 2^48
    assign elapsed = i_now_ms - i_state.last_raise_ms;
    assign cool_ok = (elapsed > {16'd0, i_cfg.cooldown_ms}) ||
                     (i_state.last_raise_ms == 48'd0);

    always_comb begin
        o_state = i_state;
        if (i_kind || (det == CLASS_NONE)) begin
            o_state.active_alert    = CLASS_NONE;
            o_state.candidate_class = CLASS_NONE;
            o_state.breach_run      = 8'd0;
        end else begin
            o_state.candidate_class = det;
            o_state.breach_run      = run_new;
            if ((run_new >= i_cfg.debounce_count) && (i_state.active_alert != det)
                && cool_ok) begin
                o_state.active_alert  = det;
                o_state.last_raise_ms = i_now_ms;
            end
        end
    end

endmodule

### src/debounced_current_alarm.sv
// Debounced current alarm top level: input register, alarm update, result register.
//
//  channel | dir | handshake                 | payload
//  --------+-----+---------------------------+---------------------------------
//  in      | in  | i_in_valid / o_in_ready   | i_kind, i_current_ma, i_now_ms
//  out     | out | o_out_valid / i_out_ready | o_alert, o_alert_active
//  cfg     | in  | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One beat per cycle unless the result stalls; beats pass input then result register.
// The alarm state is read and written in the single stage between the input
// register and the result register, so back-to-back beats see each other.
// A stalled result holds the result register; the input register keeps taking
// beats as long as it drains, so ready drops only when both registers are full.
// Synchronous active-low reset clears valids, alarm state and loads config defaults.
// Config writes are always taken; the user must issue them only while idle, unchecked.
module debounced_current_alarm
    import dca_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // item channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_kind,
    input  logic signed [15:0] i_current_ma,
    input  logic [47:0]        i_now_ms,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_alert,
    output logic               o_alert_active,
    // config channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    t_cfg               r_cfg;
    t_state             r_state;
    t_state             n_state;

    logic               r_in_valid;
    logic               r_in_kind;
    logic signed [15:0] r_in_current_ma;
    logic [47:0]        r_in_now_ms;

    logic               r_out_valid;
    t_class             r_out_alert;

    logic               advance;   // input register moves into result register
    logic               in_beat;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign in_beat    = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    // Config register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_count    <= RST_DEBOUNCE;
            r_cfg.cooldown_ms       <= RST_COOLDOWN;
            r_cfg.high_threshold_ma <= RST_HIGH_THR;
            r_cfg.low_threshold_ma  <= RST_LOW_THR;
            r_cfg.floor_ma          <= RST_FLOOR;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_DEBOUNCE: r_cfg.debounce_count    <= i_cfg_data[7:0];
                REG_COOLDOWN: r_cfg.cooldown_ms       <= i_cfg_data;
                REG_HIGH_THR: r_cfg.high_threshold_ma <= i_cfg_data[15:0];
                REG_LOW_THR:  r_cfg.low_threshold_ma  <= i_cfg_data[15:0];
                REG_FLOOR:    r_cfg.floor_ma          <= i_cfg_data[15:0];
                default: ;    // unknown index ignored
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_in_kind       <= i_kind;
            r_in_current_ma <= i_current_ma;
            r_in_now_ms     <= i_now_ms;
        end
    end

    dca_step u_step (
        .i_cfg        (r_cfg),
        .i_state      (r_state),
        .i_kind       (r_in_kind),
        .i_current_ma (r_in_current_ma),
        .i_now_ms     (r_in_now_ms),
        .o_state      (n_state)
    );

    // Alarm state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.active_alert    <= CLASS_NONE;
            r_state.candidate_class <= CLASS_NONE;
            r_state.breach_run      <= 8'd0;
            r_state.last_raise_ms   <= 48'd0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_alert <= n_state.active_alert;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_alert        = r_out_alert;
    assign o_alert_active = (r_out_alert != CLASS_NONE);

endmodule

### src/dca_checker.sv
// Port-level checks for the debounced current alarm, bound to the top level.
module dca_checker
    import dca_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_alert,
    input logic        o_alert_active
);

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // Active flag agrees with the alert class
    a_active_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_alert_active == (o_alert != CLASS_NONE)))
        else $error("alert_active disagrees with alert");

    // An empty result register never blocks the item side
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty result register");

    // Stalled result beat holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_alert)))
        else $error("stalled result beat changed");

endmodule

bind debounced_current_alarm dca_checker u_dca_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_alert        (o_alert),
    .o_alert_active (o_alert_active)
);

### bench/dca_tb_pkg.sv
// Bench package for the debounced current alarm: item kinds and the alarm scoreboard.
package dca_tb_pkg;
    import dca_pkg::*;

    localparam logic KIND_READING = 1'b0;
    localparam logic KIND_CLEAR   = 1'b1;

    class alarm_scoreboard;
        // register copies
        logic [7:0]         debounce;
        logic [31:0]        cooldown;
        logic signed [15:0] hi_thr;
        logic signed [15:0] lo_thr;
        logic signed [15:0] floor_lvl;
        // alarm state
        t_class             alert_now;
        t_class             cand;
        logic [7:0]         run_len;
        logic [47:0]        last_raise;   // zero reads as never raised
        // alerts still owed by the block, oldest first
        t_class             alert_q[$];
        int                 errors;

        function new();
            debounce   = RST_DEBOUNCE;
            cooldown   = RST_COOLDOWN;
            hi_thr     = RST_HIGH_THR;
            lo_thr     = RST_LOW_THR;
            floor_lvl  = RST_FLOOR;
            alert_now  = CLASS_NONE;
            cand       = CLASS_NONE;
            run_len    = '0;
            last_raise = '0;
            errors     = 0;
        endfunction

        function void apply_reg(logic [2:0] idx, logic [31:0] data);
            case (idx)
                REG_DEBOUNCE: debounce  = data[7:0];
                REG_COOLDOWN: cooldown  = data;
                REG_HIGH_THR: hi_thr    = data[15:0];
                REG_LOW_THR:  lo_thr    = data[15:0];
                REG_FLOOR:    floor_lvl = data[15:0];
                default: ;
            endcase
        endfunction

        // high wins; low needs to sit strictly between floor and low threshold
        function t_class sort_sample(logic signed [15:0] cur);
            if (cur > hi_thr) return CLASS_HIGH;
            if (cur > floor_lvl && cur < lo_thr) return CLASS_LOW;
            return CLASS_NONE;
        endfunction

        function void note_item(logic kind, logic signed [15:0] cur, logic [47:0] now);
            t_class      seen;
            logic [47:0] elapsed;
            seen = (kind == KIND_CLEAR) ? CLASS_NONE : sort_sample(cur);
            if (seen == CLASS_NONE) begin
                alert_now = CLASS_NONE;
                cand      = CLASS_NONE;
                run_len   = '0;
            end else begin
                if (seen == cand) begin
                    if (run_len != RUN_MAX) run_len++;
                end else begin
                    cand    = seen;
                    run_len = 8'd1;
                end
                if (run_len >= debounce && alert_now != seen) begin
                    elapsed = now - last_raise;   // wraps at 48 bits
                    if (elapsed > {16'd0, cooldown} || last_raise == '0) begin
                        alert_now  = seen;
                        last_raise = now;
                    end
                end
            end
            alert_q.push_back(alert_now);
        endfunction

        function void check_result(logic [1:0] alert, logic active);
            t_class want;
            logic   want_active;
            if (alert_q.size() == 0) begin
                $error("alert: no beat expected, actual %0d", alert);
                errors++;
                return;
            end
            want        = alert_q.pop_front();
            want_active = (want != CLASS_NONE);
            if (alert !== want) begin
                $error("alert: expected %0d, actual %0d", want, alert);
                errors++;
            end
            if (active !== want_active) begin
                $error("alert_active: expected %0d, actual %0d", want_active, active);
                errors++;
            end
        endfunction

        function int pending();
            return alert_q.size();
        endfunction
    endclass
endpackage

### bench/debounced_current_alarm_tb.sv
// Top-level bench for the debounced current alarm: stimulus, result side and watchdog.
module debounced_current_alarm_tb;
    import dca_pkg::*;
    import dca_tb_pkg::*;

    localparam int STALL_LIMIT = 2000;   // cycles without any beat before giving up
    localparam int SETTLE      = 4;      // block latency plus margin

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic               i_kind = KIND_READING;
    logic signed [15:0] i_current_ma = '0;
    logic [47:0]        i_now_ms = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [1:0]         o_alert;
    logic               o_alert_active;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index = REG_DEBOUNCE;
    logic [31:0]        i_cfg_data = '0;

    alarm_scoreboard sb;
    logic [47:0]     t_now = '0;    // running timestamp for readings
    bit              in_calm = 1'b0;   // set: sender never pauses

    debounced_current_alarm dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_kind         (i_kind),
        .i_current_ma   (i_current_ma),
        .i_now_ms       (i_now_ms),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_alert        (o_alert),
        .o_alert_active (o_alert_active),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Idle length: mostly none or short, now and then a long one.
    function automatic int pick_gap(bit calm);
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [47:0] random_stamp();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[47:0];
    endfunction

    // Advance the reading clock. A good share lands exactly on the cooldown edge
    // (equal or one past); the rest are small steps, jumps, zero and wrap.
    function automatic logic [47:0] next_time();
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9: t_now = t_now + 48'($urandom_range(0, 20));
            10, 11, 12, 13: t_now = sb.last_raise + {16'd0, sb.cooldown}
                                    + 48'($urandom_range(0, 1));
            14, 15: t_now = t_now + {16'd0, sb.cooldown / $urandom_range(1, 4)};
            16: t_now = random_stamp();
            17: t_now = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 5));
            18: t_now = '0;
            default: t_now = t_now + {16'd0, $urandom};
        endcase
        return t_now;
    endfunction

    // Find a sample of the wanted class: random values plus probes around each
    // threshold. Falls back to the last try when the settings rule the class out.
    function automatic logic signed [15:0] pick_current(t_class want);
        logic signed [15:0] c;
        logic [15:0]        d;
        c = '0;
        for (int i = 0; i < 48; i++) begin
            d = 16'($urandom_range(0, 4)) - 16'd2;
            case ($urandom_range(0, 3))
                0: c = 16'($urandom);
                1: c = sb.hi_thr + d;
                2: c = sb.lo_thr + d;
                default: c = sb.floor_lvl + d;
            endcase
            if (sb.sort_sample(c) == want) return c;
        end
        return c;
    endfunction

    // One input beat; called and left at a falling edge. Valid stays up when
    // the next beat follows with no gap.
    task automatic send_item(input logic kind, input logic signed [15:0] cur,
                             input logic [47:0] now);
        int gap;
        gap = pick_gap(in_calm);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_kind       <= kind;
        i_current_ma <= cur;
        i_now_ms     <= now;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_item(kind, cur, now);
        @(negedge i_clk);
    endtask

    // Quiesce: stop sending, wait for every owed result, then the pipe latency.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.apply_reg(idx, data);
        @(negedge i_clk);
    endtask

    // Full register load while idle. Unused upper data bits carry noise, and a
    // stray write to an unmapped index follows, which must change nothing.
    task automatic load_cfg(input logic [7:0] deb, input logic [31:0] cool,
                            input logic signed [15:0] hi, input logic signed [15:0] lo,
                            input logic signed [15:0] fl);
        logic [31:0] noise;
        drain_results();
        noise = $urandom;
        write_reg(REG_DEBOUNCE, {noise[31:8], deb});
        write_reg(REG_COOLDOWN, cool);
        noise = $urandom;
        write_reg(REG_HIGH_THR, {noise[31:16], hi});
        noise = $urandom;
        write_reg(REG_LOW_THR, {noise[31:16], lo});
        noise = $urandom;
        write_reg(REG_FLOOR, {noise[31:16], fl});
        write_reg(REG_FLOOR + 3'($urandom_range(1, 3)), $urandom);
        i_cfg_valid <= 1'b0;
    endtask

    // Random traffic built from runs: mostly runs of one class long enough to
    // clear the debounce, some cut short, a few past counter saturation, with
    // no-current readings, clears and odd-class noise in between.
    task automatic run_phase(input int n_items);
        int     left;
        int     len;
        int     r;
        t_class want;
        t_class other;
        left = n_items;
        while (left > 0) begin
            if ($urandom_range(0, 9) == 0) in_calm = !in_calm;
            r = $urandom_range(0, 99);
            if (r < 6) begin
                send_item(KIND_CLEAR, 16'($urandom), random_stamp());
                left--;
            end else if (r < 18) begin
                len = $urandom_range(1, 3);
                repeat (len) send_item(KIND_READING, pick_current(CLASS_NONE), next_time());
                left -= len;
            end else begin
                want = ($urandom_range(0, 1) != 0) ? CLASS_HIGH : CLASS_LOW;
                r    = $urandom_range(0, 19);
                if (r == 0)
                    len = $urandom_range(256, 300);
                else if (r < 5)
                    len = $urandom_range(1, (sb.debounce > 1) ? int'(sb.debounce) : 1);
                else
                    len = int'(sb.debounce) + $urandom_range(0, 6);
                if (len == 0) len = 1;
                repeat (len) begin
                    if ($urandom_range(0, 39) == 0) begin
                        other = ($urandom_range(0, 1) != 0) ? CLASS_NONE
                              : ((want == CLASS_HIGH) ? CLASS_LOW : CLASS_HIGH);
                        send_item(KIND_READING, pick_current(other), next_time());
                    end else begin
                        send_item(KIND_READING, pick_current(want), next_time());
                    end
                end
                left -= len;
            end
        end
    endtask

    // Result side: check each beat taken, then choose ready for the next cycle.
    initial begin : result_side
        int stall_left;
        bit calm_out;
        stall_left = 0;
        calm_out   = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready)
                sb.check_result(o_alert, o_alert_active);
            @(negedge i_clk);
            if ($urandom_range(0, 199) == 0) calm_out = !calm_out;
            if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else begin
                i_out_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) stall_left = pick_gap(calm_out);
            end
        end
    end

    // Watchdog: any channel moving a beat resets the count.
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                    || (i_cfg_valid && o_cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("debounced_current_alarm test failed");
        $finish;
    end

    initial begin : stimulus
        logic [7:0]         deb;
        logic [31:0]        cool;
        logic signed [15:0] fl;
        logic signed [15:0] hi;
        logic signed [15:0] lo;
        sb = new();
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset settings: debounce 3, cooldown 60000, high above 10000,
        // low in (150, 1000). First raise goes through since nothing was raised.
        send_item(KIND_READING, 16'sd12000, 48'd1000);
        send_item(KIND_READING, 16'sd12000, 48'd1010);
        send_item(KIND_READING, 16'sd10001, 48'd1020);
        send_item(KIND_READING, 16'sh7FFF, 48'd1030);
        // low run debounced but held by the cooldown, first at equality
        send_item(KIND_READING, 16'sd500, 48'd1040);
        send_item(KIND_READING, 16'sd151, 48'd1050);
        send_item(KIND_READING, 16'sd999, 48'd1060);
        send_item(KIND_READING, 16'sd500, 48'd61020);
        send_item(KIND_READING, 16'sd500, 48'd61021);
        // no-current cases at each edge
        send_item(KIND_READING, 16'sd150, 48'd61030);
        send_item(KIND_READING, 16'sd1000, 48'd61040);
        send_item(KIND_READING, 16'sd10000, 48'd61050);
        send_item(KIND_READING, 16'sh8000, 48'd61060);
        // clear restarts the run; its payload is ignored
        send_item(KIND_READING, 16'sd12000, 48'd61100);
        send_item(KIND_CLEAR, 16'sh7FFF, 48'hFFFF_FFFF_FFFF);
        send_item(KIND_READING, 16'sd12000, 48'd61110);
        send_item(KIND_READING, 16'sd12000, 48'd61120);
        // raise at time zero, which still reads as never raised afterwards
        send_item(KIND_READING, 16'sd12000, 48'd0);
        send_item(KIND_READING, 16'sd500, 48'd5);
        send_item(KIND_READING, 16'sd500, 48'd6);
        send_item(KIND_READING, 16'sd500, 48'd7);
        // elapsed time across the 48-bit wrap
        send_item(KIND_READING, 16'sd12000, 48'hFFFF_FFFF_FFF0);
        send_item(KIND_READING, 16'sd12000, 48'hFFFF_FFFF_FFF1);
        send_item(KIND_READING, 16'sd12000, 48'hFFFF_FFFF_FFF2);
        send_item(KIND_READING, 16'sd500, 48'd100);

        // single-sample debounce, no cooldown
        load_cfg(8'd1, 32'd0, 16'sd2000, 16'sd1500, 16'sd0);
        run_phase(200);
        // zero debounce; nearly everything is high
        load_cfg(8'd0, 32'd5, 16'sh8000, 16'sh7FFF, 16'sh8000);
        run_phase(150);
        // longest debounce and cooldown; high unreachable, run saturates
        load_cfg(8'd255, 32'hFFFF_FFFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000);
        run_phase(400);
        // crossed thresholds: high below both floor and low threshold
        load_cfg(8'd2, 32'd100, -16'sd100, 16'sd500, 16'sd300);
        run_phase(100);
        // crossed the other way: low threshold above high
        load_cfg(8'd3, 32'd40, 16'sd5000, 16'sd8000, -16'sd5000);
        run_phase(100);
        repeat (2) begin
            deb  = 8'($urandom_range(1, 6));
            cool = $urandom_range(0, 3000);
            fl   = 16'($urandom_range(0, 2000)) - 16'sd1000;
            lo   = fl + 16'($urandom_range(200, 900));
            hi   = fl + 16'($urandom_range(1000, 3000));
            load_cfg(deb, cool, hi, lo, fl);
            run_phase(175);
        end

        drain_results();
        repeat (SETTLE) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("debounced_current_alarm test passed");
        else
            $display("debounced_current_alarm test failed");
        $finish;
    end
endmodule

### sim.f
src/dca_pkg.sv
src/dca_step.sv
src/debounced_current_alarm.sv
src/dca_checker.sv
bench/dca_tb_pkg.sv
bench/debounced_current_alarm_tb.sv
